// File: sv/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_LPAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    TK_NUM  = 3'd0,
    TK_OP   = 3'd1,
    TK_LPAR = 3'd2,
    TK_RPAR = 3'd3,
    TK_END  = 3'd4,
    TK_BAD  = 3'd5
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [ValueW-1:0]  data;  // number, or operator code in low bits
  } token_t;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // True when stacked operator t binds at least as tightly as incoming op.
  function automatic logic prec_ge(op_e t, op_e op);
    logic t_hi;
    logic op_hi;
    t_hi  = (t == OP_MUL) || (t == OP_DIV);
    op_hi = (op == OP_MUL) || (op == OP_DIV);
    return t_hi || !op_hi;
  endfunction

endpackage

// File: sv/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/iee_front.sv
// ----------------------------------------------------------------------------
// iee_front
// Character classifier: builds decimal numbers and emits tokens.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_expr_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output iee_pkg::token_t tok_o
);
  import iee_pkg::*;

  logic              in_num_q, in_num_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              pend_q, pend_d;
  token_t            pend_tok_q, pend_tok_d;
  token_t            cls_tok;
  logic              is_digit;
  logic              accept;

  // Classify the incoming character.
  always_comb begin
    is_digit      = (char_code_i >= ChZero) && (char_code_i <= ChNine);
    cls_tok.data  = '0;
    cls_tok.kind  = TK_BAD;
    if (end_of_expr_i) begin
      cls_tok.kind = TK_END;
    end else begin
      case (char_code_i)
        ChPlus:  begin cls_tok.kind = TK_OP; cls_tok.data[2:0] = OP_ADD; end
        ChMinus: begin cls_tok.kind = TK_OP; cls_tok.data[2:0] = OP_SUB; end
        ChStar:  begin cls_tok.kind = TK_OP; cls_tok.data[2:0] = OP_MUL; end
        ChSlash: begin cls_tok.kind = TK_OP; cls_tok.data[2:0] = OP_DIV; end
        ChLpar:  cls_tok.kind = TK_LPAR;
        ChRpar:  cls_tok.kind = TK_RPAR;
        default: cls_tok.kind = TK_BAD;
      endcase
    end
  end

  assign ready_o = !pend_q && tok_ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    in_num_d    = in_num_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    pend_tok_d  = pend_tok_q;
    tok_valid_o = 1'b0;
    tok_o       = cls_tok;
    if (pend_q) begin
      tok_valid_o = 1'b1;
      tok_o       = pend_tok_q;
      if (tok_ready_i) begin
        pend_d = 1'b0;
      end
    end else if (accept) begin
      if (!end_of_expr_i && is_digit) begin
        // acc * 10 + digit
        acc_d    = (acc_q << 3) + (acc_q << 1) + ValueW'(char_code_i - ChZero);
        in_num_d = 1'b1;
      end else begin
        tok_valid_o = 1'b1;
        in_num_d    = 1'b0;
        acc_d       = '0;
        // A stray character flags without flushing the number.
        if (in_num_q && cls_tok.kind != TK_BAD) begin
          tok_o.kind = TK_NUM;
          tok_o.data = acc_q;
          pend_d     = 1'b1;
          pend_tok_d = cls_tok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_num_q <= 1'b0;
      acc_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      in_num_q <= in_num_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tok_q <= pend_tok_d;
  end

endmodule

// File: sv/iee_fifo.sv
// ----------------------------------------------------------------------------
// iee_fifo
// Two-entry token queue between the classifier and the stack engine.
// ----------------------------------------------------------------------------
module iee_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wvalid_i,
  output logic            wready_o,
  input  iee_pkg::token_t wdata_i,
  output logic            rvalid_o,
  input  logic            rready_i,
  output iee_pkg::token_t rdata_o
);
  import iee_pkg::*;

  token_t     slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wready_o = (cnt_q != 2'd2);
  assign rvalid_o = (cnt_q != 2'd0);
  assign rdata_o  = slot_q[rptr_q];
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/iee_div.sv
// ----------------------------------------------------------------------------
// iee_div
// Signed 32-bit divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [iee_pkg::ValueW-1:0] dividend_i,
  input  logic [iee_pkg::ValueW-1:0] divisor_i,
  output logic                      done_o,
  output logic [iee_pkg::ValueW-1:0] quot_o
);
  import iee_pkg::*;

  localparam int unsigned CntW = $clog2(ValueW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic [ValueW:0]   rem_q;
  logic [ValueW-1:0] quo_q;
  logic [ValueW-1:0] den_q;
  logic [ValueW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q[ValueW-1:0], quo_q[ValueW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ValueW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[ValueW-1] ^ divisor_i[ValueW-1];
      rem_q <= '0;
      quo_q <= dividend_i[ValueW-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_q <= divisor_i[ValueW-1] ? (~divisor_i + 1'b1) : divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[ValueW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: sv/iee_back.sv
// ----------------------------------------------------------------------------
// iee_back
// Stack engine: value and operator stacks, reductions, result register.
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int unsigned VALUE_DEPTH    = 16,
  parameter int unsigned OPERATOR_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tok_valid_i,
  output logic                       tok_ready_o,
  input  iee_pkg::token_t            tok_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [iee_pkg::ValueW-1:0] res_value_o,
  output iee_pkg::status_e           res_status_o
);
  import iee_pkg::*;

  localparam int unsigned VCntW = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned OCntW = $clog2(OPERATOR_DEPTH + 1);
  localparam int unsigned VAW   = $clog2(VALUE_DEPTH);
  localparam int unsigned OAW   = $clog2(OPERATOR_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DEC, S_RA, S_RB, S_EXE, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e            state_q;
  logic [VCntW-1:0]  vtop_q;
  logic [OCntW-1:0]  otop_q;
  status_e           err_q;
  tok_kind_e         kind_q;
  op_e               tok_op_q;
  op_e               rop_q;
  logic [ValueW-1:0] a_q;
  logic              res_valid_q;
  logic [ValueW-1:0] res_value_q;
  status_e           res_status_q;

  logic              v_we, v_re, o_we, o_re;
  logic [VAW-1:0]    v_waddr, v_raddr;
  logic [OAW-1:0]    o_waddr, o_raddr;
  logic [ValueW-1:0] v_wdata, v_rdata;
  op_e               o_wdata;
  logic [2:0]        o_rdata;
  op_e               top_op;
  logic              has_op;
  logic              red_go;
  logic              v_full, o_full;
  logic              div_start, div_done;
  logic [ValueW-1:0] div_quot;
  logic [ValueW-1:0] alu_res;
  logic              out_free;
  logic [VCntW-1:0]  vtop_m1, vtop_m2;
  logic [OCntW-1:0]  otop_m1;

  iee_ram #(.Width(ValueW), .Depth(VALUE_DEPTH)) u_vstack (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(v_re), .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  iee_ram #(.Width(3), .Depth(OPERATOR_DEPTH)) u_ostack (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  iee_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(v_rdata),
    .divisor_i(a_q), .done_o(div_done), .quot_o(div_quot)
  );

  assign top_op   = op_e'(o_rdata);
  assign has_op   = (otop_q != '0);
  assign v_full   = (vtop_q == VCntW'(VALUE_DEPTH));
  assign o_full   = (otop_q == OCntW'(OPERATOR_DEPTH));
  assign vtop_m1  = vtop_q - 1'b1;
  assign vtop_m2  = vtop_q - 2'd2;
  assign otop_m1  = otop_q - 1'b1;
  assign out_free = !res_valid_q || res_ready_i;
  assign tok_ready_o = (state_q == S_IDLE);

  // Decode step: the top operator is reduced before the token goes on.
  assign red_go = (err_q == ST_OK) && has_op && (top_op != OP_LPAR) &&
                  ((kind_q != TK_OP) || prec_ge(top_op, tok_op_q));

  always_comb begin
    case (rop_q)
      OP_ADD:  alu_res = v_rdata + a_q;
      OP_SUB:  alu_res = v_rdata - a_q;
      default: alu_res = v_rdata * a_q;
    endcase
  end

  // Memory port control.
  always_comb begin
    v_we      = 1'b0;
    v_waddr   = vtop_q[VAW-1:0];
    v_wdata   = tok_i.data;
    v_re      = 1'b0;
    v_raddr   = vtop_m1[VAW-1:0];
    o_we      = 1'b0;
    o_waddr   = otop_q[OAW-1:0];
    o_wdata   = OP_LPAR;
    o_re      = 1'b0;
    o_raddr   = otop_m1[OAW-1:0];
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (tok_valid_i && err_q == ST_OK) begin
          v_we = (tok_i.kind == TK_NUM) && !v_full;
          o_we = (tok_i.kind == TK_LPAR) && !o_full;
        end
      end
      S_CHK: o_re = has_op;
      S_DEC: begin
        o_wdata = tok_op_q;
        o_we    = (kind_q == TK_OP) && (err_q == ST_OK) && !o_full && !red_go;
      end
      S_RA: v_re = 1'b1;
      S_RB: begin
        v_re    = 1'b1;
        v_raddr = vtop_m2[VAW-1:0];
      end
      S_EXE: begin
        v_waddr   = vtop_m2[VAW-1:0];
        v_wdata   = alu_res;
        v_we      = (rop_q != OP_DIV);
        div_start = (rop_q == OP_DIV) && (a_q != '0);
      end
      S_DIV: begin
        v_waddr = vtop_m2[VAW-1:0];
        v_wdata = div_quot;
        v_we    = div_done;
      end
      S_FIN: begin
        v_re    = 1'b1;
        v_raddr = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vtop_q      <= '0;
      otop_q      <= '0;
      err_q       <= ST_OK;
      kind_q      <= TK_END;
      tok_op_q    <= OP_ADD;
      rop_q       <= OP_ADD;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i && state_q != S_OUT) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (tok_valid_i) begin
            kind_q   <= tok_i.kind;
            tok_op_q <= op_e'(tok_i.data[2:0]);
            if (err_q == ST_OK || tok_i.kind == TK_END) begin
              case (tok_i.kind)
                TK_NUM: begin
                  if (v_full) err_q <= ST_OVERFLOW;
                  else        vtop_q <= vtop_q + 1'b1;
                end
                TK_LPAR: begin
                  if (o_full) err_q <= ST_OVERFLOW;
                  else        otop_q <= otop_q + 1'b1;
                end
                TK_BAD:  err_q   <= ST_SYNTAX;
                default: state_q <= S_CHK;
              endcase
            end
          end
        end
        S_CHK: state_q <= S_DEC;
        S_DEC: begin
          if (red_go) begin
            otop_q <= otop_m1;
            rop_q  <= top_op;
            if (vtop_q < VCntW'(2)) begin
              err_q   <= ST_SYNTAX;
              state_q <= S_CHK;
            end else begin
              state_q <= S_RA;
            end
          end else begin
            state_q <= (kind_q inside {TK_OP, TK_RPAR}) ? S_IDLE : S_FIN;
            if (err_q == ST_OK) begin
              case (kind_q)
                TK_RPAR: begin
                  // Top is the matching '(' or the stack is empty.
                  if (has_op) otop_q <= otop_m1;
                  else        err_q  <= ST_SYNTAX;
                end
                TK_OP: begin
                  if (o_full) err_q  <= ST_OVERFLOW;
                  else        otop_q <= otop_q + 1'b1;
                end
                default: begin
                  // End of expression: anything left here is an open '('.
                  if (has_op) err_q <= ST_SYNTAX;
                end
              endcase
            end
          end
        end
        S_RA: state_q <= S_RB;
        S_RB: state_q <= S_EXE;
        S_EXE: begin
          if (rop_q != OP_DIV) begin
            vtop_q  <= vtop_m1;
            state_q <= S_CHK;
          end else if (a_q == '0) begin
            vtop_q  <= vtop_m2;
            err_q   <= ST_DIVZERO;
            state_q <= S_CHK;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            vtop_q  <= vtop_m1;
            state_q <= S_CHK;
          end
        end
        S_FIN: begin
          if (err_q == ST_OK && vtop_q != VCntW'(1)) begin
            err_q <= ST_SYNTAX;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= (err_q == ST_OK) ? v_rdata : '0;
            res_status_q <= err_q;
            vtop_q       <= '0;
            otop_q       <= '0;
            err_q        <= ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RB) begin
      a_q <= v_rdata;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_value_o  = res_value_q;
  assign res_status_o = res_status_q;

endmodule

// File: sv/infix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// Two-stack infix evaluator: characters in, one value and status per
// expression out.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_axis   in   tdata[7:0] char_code, tlast end_of_expr (char ignored)
// m_axis   out  tdata[31:0] value, tdata[33:32] status, rest zero
//
// A digit only extends the current number. An operator or bracket goes
// through the token queue; each reduction reads two operands and writes
// back one result, and a division also runs the shift-subtract divider.
// The end request waits for the final unwind and a free result register.
// Reset clears stack pointers, error state and the queue; stack RAMs are
// not cleared. Either side may stall; the queue and result register hold.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top #(
  parameter int unsigned VALUE_DEPTH    = 16,
  parameter int unsigned OPERATOR_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] value, [33:32] status
);
  import iee_pkg::*;

  logic              f_valid, f_ready, q_valid, q_ready;
  token_t            f_tok, q_tok;
  logic [ValueW-1:0] res_value;
  status_e           res_status;

  // Front: character classification and number building.
  iee_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid_i), .ready_o(s_axis_tready_o),
    .char_code_i(s_axis_tdata_i), .end_of_expr_i(s_axis_tlast_i),
    .tok_valid_o(f_valid), .tok_ready_i(f_ready), .tok_o(f_tok)
  );

  // Decoupling queue.
  iee_fifo u_fifo (
    .clk_i, .rst_ni,
    .wvalid_i(f_valid), .wready_o(f_ready), .wdata_i(f_tok),
    .rvalid_o(q_valid), .rready_i(q_ready), .rdata_o(q_tok)
  );

  // Back: stacks, reductions, divider, result register.
  iee_back #(
    .VALUE_DEPTH(VALUE_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)
  ) u_back (
    .clk_i, .rst_ni,
    .tok_valid_i(q_valid), .tok_ready_o(q_ready), .tok_i(q_tok),
    .res_valid_o(m_axis_tvalid_o), .res_ready_i(m_axis_tready_i),
    .res_value_o(res_value), .res_status_o(res_status)
  );

  assign m_axis_tdata_o = {6'd0, res_status, res_value};

  // An error result always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[33:32] != ST_OK) |-> m_axis_tdata_o[31:0] == '0)
    else $error("error result with non-zero value");

  // The front offers a token to a full queue only while it takes no input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid |-> f_ready || !s_axis_tready_o)
    else $error("token lost at queue");

  // A pending result stays valid until it has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("pending result dropped");

endmodule
